### hdl/hcpd_pkg.sv
package hcpd_pkg;

  localparam int PERIOD_W = 16;
  localparam int THR_W    = 11;
  localparam int SAMPLE_W = 10;
  localparam int PROD_W   = PERIOD_W + THR_W;
  localparam int STEP_W   = 4;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_PINS     = 2'd1;
  localparam logic [1:0] FUNC_THROTTLE = 2'd2;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_SPAN   = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [THR_W-1:0]    OFFSET_RST = 11'd1551;
  localparam logic [THR_W-1:0]    SPAN_RST   = 11'd330;

  typedef struct packed {
    logic [1:0]          func;
    logic [2:0]          hall_pins;
    logic [1:0]          brake_pins;
    logic [SAMPLE_W-1:0] throttle_sample;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          high_gates;
    logic [2:0]          low_gates;
    logic [PERIOD_W-1:0] duty_now;
    logic                led_on;
  } drv_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/hcpd_div.sv
module hcpd_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hcpd_pkg::PERIOD_W-1:0]   period,
  input  logic [hcpd_pkg::THR_W-1:0]      num,
  input  logic [hcpd_pkg::THR_W-1:0]      span,
  output hcpd_pkg::div_stat_t             stat,
  output logic [hcpd_pkg::PERIOD_W-1:0]   quot
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]                        state;
  logic [hcpd_pkg::PERIOD_W-1:0]     mul_a;
  logic [hcpd_pkg::THR_W-1:0]        mul_b;
  logic [hcpd_pkg::THR_W-1:0]        dvsr;
  logic [hcpd_pkg::THR_W-1:0]        rem;
  logic [hcpd_pkg::PERIOD_W-1:0]     dvd;
  logic [hcpd_pkg::STEP_W-1:0]       cnt;
  logic                              done;
  logic [hcpd_pkg::PROD_W-1:0]       prod;
  logic [hcpd_pkg::THR_W:0]          trial;
  logic                              fits;

  // one product, then one restoring step per cycle; dvd shifts quotient bits in
  assign prod  = {{hcpd_pkg::THR_W{1'b0}}, mul_a} * {{hcpd_pkg::PERIOD_W{1'b0}}, mul_b};
  assign trial = {rem, dvd[hcpd_pkg::PERIOD_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == {hcpd_pkg::STEP_W{1'b1}}) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mul_a <= period;
      mul_b <= num;
      dvsr  <= span;
    end
    if (state == S_MUL) begin
      rem <= prod[hcpd_pkg::PROD_W-1:hcpd_pkg::PERIOD_W];
      dvd <= prod[hcpd_pkg::PERIOD_W-1:0];
    end else if (state == S_DIV) begin
      rem <= fits ? hcpd_pkg::THR_W'(trial - {1'b0, dvsr}) : trial[hcpd_pkg::THR_W-1:0];
      dvd <= {dvd[hcpd_pkg::PERIOD_W-2:0], fits};
    end
  end

  assign stat.busy = state != S_IDLE;
  assign stat.done = done;
  assign quot      = dvd;

endmodule

### hdl/hcpd_ofifo.sv
module hcpd_ofifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcpd_pkg::drv_t din,
  input  logic           stall,
  output logic           valid,
  output hcpd_pkg::drv_t dout,
  output logic           full
);

  hcpd_pkg::drv_t slot0;
  hcpd_pkg::drv_t slot1;
  logic [1:0]     count;
  logic           pop;

  assign valid = count != 2'd0;
  assign full  = count == 2'd2;
  assign pop   = valid && !stall;
  assign dout  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (push) begin
          slot1 <= din;
        end
      end else if (push) begin
        slot0 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule

### hdl/hall_commutation_pwm_drive.sv
// Hall-sensor six-step commutation and throttle PWM gate driver.
// cmd channel (cmd_valid/cmd_stall, payload cmd): one item per transfer,
//   func selects timer tick, hall/brake pin change or throttle sample.
// drv channel (drv_valid/drv_stall, payload drv): exactly one result per
//   command, showing gates, duty and LED after that command.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): period, offset and
//   span registers; cfg_ready is always high. Write only while idle.
// Ticks and pin changes: the result is queued at the transfer edge and shows
//   on drv the next cycle unless an older result waits; a new command is
//   taken every cycle while cmd_stall is low.
// Throttle samples that fall inside the span go through the multiply/divide
//   unit: a multiply step, 16 restoring divide steps and a commit step, with
//   cmd_stall high throughout; the result is queued at commit and the next
//   command is taken after it. Other throttle samples are handled like ticks.
// Results wait in a two-entry output queue; apart from a divide, cmd_stall
//   rises only when the queue is full, so one result may wait on drv_stall
//   while the next command is still taken.
// Reset (rst, synchronous) restores the register defaults, clears the masks,
//   counter and duty, turns all gates and the LED off and empties the queue.
module hall_commutation_pwm_drive (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  hcpd_pkg::cmd_t                cmd,
  output logic                          drv_valid,
  input  logic                          drv_stall,
  output hcpd_pkg::drv_t                drv,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hcpd_pkg::PERIOD_W-1:0] cfg_data
);

  logic [hcpd_pkg::PERIOD_W-1:0] period;
  logic [hcpd_pkg::THR_W-1:0]    offset;
  logic [hcpd_pkg::THR_W-1:0]    span;
  logic [2:0]                    last_halls;
  logic [2:0]                    high_mask;
  logic [2:0]                    low_mask;
  logic [hcpd_pkg::PERIOD_W-1:0] pwm_count;
  logic [hcpd_pkg::PERIOD_W-1:0] duty_value;
  logic                          throttle_active;
  logic [2:0]                    gate_hi;
  logic [2:0]                    gate_lo;
  logic                          led_flag;

  logic [2:0]                    last_halls_next;
  logic [2:0]                    high_mask_next;
  logic [2:0]                    low_mask_next;
  logic [hcpd_pkg::PERIOD_W-1:0] pwm_count_next;
  logic [hcpd_pkg::PERIOD_W-1:0] duty_value_next;
  logic                          throttle_active_next;
  logic [2:0]                    gate_hi_next;
  logic [2:0]                    gate_lo_next;
  logic                          led_flag_next;

  logic                          accept;
  logic                          push;
  logic                          div_start;
  logic                          fifo_full;
  logic                          top;
  logic [hcpd_pkg::THR_W-1:0]    twice;
  logic [hcpd_pkg::THR_W-1:0]    num;
  logic [hcpd_pkg::PERIOD_W-1:0] quot;
  hcpd_pkg::div_stat_t           div_stat;
  hcpd_pkg::drv_t                result;

  function automatic logic one_hot3(input logic [2:0] m);
    return m == 3'd1 || m == 3'd2 || m == 3'd4;
  endfunction

  assign cmd_stall = div_stat.busy || div_stat.done || fifo_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  assign top   = pwm_count >= period;
  assign twice = {cmd.throttle_sample, 1'b0};
  assign num   = twice - offset;

  always_comb begin
    last_halls_next      = last_halls;
    high_mask_next       = high_mask;
    low_mask_next        = low_mask;
    pwm_count_next       = pwm_count;
    duty_value_next      = duty_value;
    throttle_active_next = throttle_active;
    gate_hi_next         = gate_hi;
    gate_lo_next         = gate_lo;
    led_flag_next        = led_flag;
    push                 = 1'b0;
    div_start            = 1'b0;
    if (div_stat.done) begin
      duty_value_next = quot;
      if (quot != '0) begin
        led_flag_next = 1'b1;
      end
      push = 1'b1;
    end else if (accept) begin
      push = 1'b1;
      unique case (cmd.func)
        hcpd_pkg::FUNC_TICK: begin
          if (top) begin
            if (throttle_active) begin
              if (one_hot3(low_mask)) begin
                gate_lo_next = low_mask;
              end
              gate_hi_next = one_hot3(high_mask) ? high_mask : 3'd0;
            end else begin
              gate_hi_next = 3'd0;
              gate_lo_next = 3'd0;
            end
          end
          if (pwm_count == duty_value) begin
            gate_hi_next = 3'd0;
          end
          pwm_count_next = top ? '0 : pwm_count + 1'b1;
        end
        hcpd_pkg::FUNC_PINS: begin
          if (cmd.brake_pins != 2'd0) begin
            high_mask_next = 3'd0;
            low_mask_next  = 3'd0;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (cmd.hall_pins[i] != last_halls[i]) begin
                if (cmd.hall_pins[i]) begin
                  low_mask_next[(i == 0) ? 2 : i - 1] = 1'b0;
                  low_mask_next[i]                    = 1'b1;
                end else begin
                  high_mask_next[(i == 0) ? 2 : i - 1] = 1'b0;
                  high_mask_next[i]                    = 1'b1;
                end
              end
            end
          end
          last_halls_next = cmd.hall_pins;
        end
        hcpd_pkg::FUNC_THROTTLE: begin
          if (twice <= offset) begin
            duty_value_next      = '0;
            throttle_active_next = 1'b0;
          end else begin
            throttle_active_next = 1'b1;
            if (num >= span) begin
              duty_value_next = period;
              if (period != '0) begin
                led_flag_next = 1'b1;
              end
            end else begin
              div_start = 1'b1;
              push      = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= hcpd_pkg::PERIOD_RST;
      offset          <= hcpd_pkg::OFFSET_RST;
      span            <= hcpd_pkg::SPAN_RST;
      last_halls      <= 3'd0;
      high_mask       <= 3'd0;
      low_mask        <= 3'd0;
      pwm_count       <= '0;
      duty_value      <= '0;
      throttle_active <= 1'b0;
      gate_hi         <= 3'd0;
      gate_lo         <= 3'd0;
      led_flag        <= 1'b0;
    end else begin
      last_halls      <= last_halls_next;
      high_mask       <= high_mask_next;
      low_mask        <= low_mask_next;
      pwm_count       <= pwm_count_next;
      duty_value      <= duty_value_next;
      throttle_active <= throttle_active_next;
      gate_hi         <= gate_hi_next;
      gate_lo         <= gate_lo_next;
      led_flag        <= led_flag_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hcpd_pkg::REG_PERIOD: period <= cfg_data;
          hcpd_pkg::REG_OFFSET: offset <= cfg_data[hcpd_pkg::THR_W-1:0];
          hcpd_pkg::REG_SPAN:   span   <= cfg_data[hcpd_pkg::THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign result.high_gates = gate_hi_next;
  assign result.low_gates  = gate_lo_next;
  assign result.duty_now   = duty_value_next;
  assign result.led_on     = led_flag_next;

  hcpd_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .period (period),
    .num    (num),
    .span   (span),
    .stat   (div_stat),
    .quot   (quot)
  );

  hcpd_ofifo u_ofifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (result),
    .stall (drv_stall),
    .valid (drv_valid),
    .dout  (drv),
    .full  (fifo_full)
  );

`ifndef SYNTH
  a_hi_onehot0: assert property (@(posedge clk) disable iff (rst) $onehot0(gate_hi))
    else $error("more than one high gate on");
  a_lo_onehot0: assert property (@(posedge clk) disable iff (rst) $onehot0(gate_lo))
    else $error("more than one low gate on");
  a_div_busy: assert property (@(posedge clk) disable iff (rst) div_start |=> div_stat.busy)
    else $error("divider did not start");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      (push && fifo_full) |-> (drv_valid && !drv_stall))
    else $error("result queue overflow");
`endif

endmodule
